[rtl/ssch_pkg.sv]
package ssch_pkg;
  localparam int unsigned CW = 32;
  localparam int unsigned TW = 17;
  localparam int unsigned SW = 5;
  localparam int unsigned XW = 50;
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [SW-1:0]        slot;
    logic signed [CW-1:0] vec_a_x;
    logic signed [CW-1:0] vec_a_y;
    logic signed [CW-1:0] vec_a_z;
    logic signed [CW-1:0] vec_b_x;
    logic signed [CW-1:0] vec_b_y;
    logic signed [CW-1:0] vec_b_z;
    logic signed [CW-1:0] offset;
    logic [TW-1:0]        best_in;
  } req_t;

  typedef struct packed {
    logic          hit;
    logic [TW-1:0] hit_time;
    logic [SW-1:0] hit_plane;
  } rsp_t;

  function automatic logic signed [CW-1:0] sat32(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] mx;
    logic signed [XW-1:0] mn;
    mx = XW'(32'sh7fffffff);
    mn = -XW'(33'sh080000000);
    if (v > mx) return 32'sh7fffffff;
    else if (v < mn) return 32'sh80000000;
    else return v[CW-1:0];
  endfunction
endpackage

[rtl/ssch_if.sv]
interface ssch_req_if;
  import ssch_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssch_rsp_if;
  import ssch_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ssch_ram.sv]
module ssch_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/swept_sphere_convex_hit_test.sv]
// Load request: accepted while idle; the block stays idle and ready for the next request.
// Query request: per plane it computes both plane values and, where the sphere crosses the
// plane, divides, forms the contact point and checks it against the other planes; then it
// returns to idle and is ready again while the result waits in the output register.
// One 32x32 multiplier and one 1-bit-per-cycle divider do all multiplication and division.
// Reset clears the plane count and control; plane stores are undefined until loaded.
module swept_sphere_convex_hit_test #(
  parameter int unsigned MAX_PLANES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssch_req_if.sink   req_i,
  ssch_rsp_if.source rsp_o
);
  import ssch_pkg::*;
  localparam int unsigned AW = $clog2(MAX_PLANES);
  localparam int unsigned NW = $clog2(MAX_PLANES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_END, S_PV, S_PV_ACC, S_EVAL, S_DIV, S_CPT, S_CHK_NEXT, S_CHK_EVAL, S_OUT
  } state_e;

  state_e state_q;
  logic [NW-1:0] total_q, n_q;
  logic [AW:0] i_q, j_q;
  logic [1:0] ax_q;
  logic [1:0] ph_q;
  req_t rq_q;
  logic signed [CW-1:0] e_q [3];
  logic signed [CW-1:0] c_q [3];
  logic signed [XW-1:0] acc_q;
  logic signed [CW-1:0] t0_q, t1_q;
  logic which_q;
  logic [47:0] rem_q;
  logic [47:0] quo_q;
  logic [5:0] dcnt_q;
  logic [TW-1:0] tm_q;
  rsp_t res_q;
  rsp_t out_q;
  logic out_v_q;

  logic [AW-1:0] raddr;
  logic signed [CW-1:0] nx, ny, nz, dd;
  logic load_we;
  assign load_we = req_i.valid && req_i.ready && req_i.data.func == FUNC_LOAD &&
                   32'(req_i.data.slot) < MAX_PLANES;
  assign raddr = (state_q == S_CHK_NEXT || state_q == S_CHK_EVAL || state_q == S_CPT)
               ? j_q[AW-1:0] : i_q[AW-1:0];

  ssch_ram #(.WIDTH(CW), .DEPTH(MAX_PLANES)) u_nx (.clk_i, .we_i(load_we),
    .waddr_i(req_i.data.slot[AW-1:0]), .wdata_i(req_i.data.vec_a_x), .raddr_i(raddr), .rdata_o(nx));
  ssch_ram #(.WIDTH(CW), .DEPTH(MAX_PLANES)) u_ny (.clk_i, .we_i(load_we),
    .waddr_i(req_i.data.slot[AW-1:0]), .wdata_i(req_i.data.vec_a_y), .raddr_i(raddr), .rdata_o(ny));
  ssch_ram #(.WIDTH(CW), .DEPTH(MAX_PLANES)) u_nz (.clk_i, .we_i(load_we),
    .waddr_i(req_i.data.slot[AW-1:0]), .wdata_i(req_i.data.vec_a_z), .raddr_i(raddr), .rdata_o(nz));
  ssch_ram #(.WIDTH(CW), .DEPTH(MAX_PLANES)) u_dd (.clk_i, .we_i(load_we),
    .waddr_i(req_i.data.slot[AW-1:0]), .wdata_i(req_i.data.offset), .raddr_i(raddr), .rdata_o(dd));

  // shared multiplier: operand selection
  logic signed [CW-1:0] ma, mb;
  logic signed [2*CW-1:0] prod;
  logic chk;
  assign chk = (state_q == S_CHK_EVAL);
  always_comb begin
    ma = nx;
    mb = rq_q.vec_a_x;
    if (state_q == S_CPT) begin
      ma = (ax_q == 2'd0) ? rq_q.vec_b_x : (ax_q == 2'd1) ? rq_q.vec_b_y : rq_q.vec_b_z;
      mb = CW'(tm_q);
    end else begin
      case (ax_q)
        2'd0: ma = nx;
        2'd1: ma = ny;
        default: ma = nz;
      endcase
      if (chk) mb = c_q[ax_q];
      else if (which_q) mb = e_q[ax_q];
      else begin
        case (ax_q)
          2'd0: mb = rq_q.vec_a_x;
          2'd1: mb = rq_q.vec_a_y;
          default: mb = rq_q.vec_a_z;
        endcase
      end
    end
  end
  assign prod = ma * mb;
  logic signed [XW-1:0] pshift;
  assign pshift = XW'(prod >>> 16);
  logic signed [XW-1:0] fin;
  assign fin = acc_q + XW'(dd) - XW'(rq_q.offset);
  logic signed [CW-1:0] fv;
  assign fv = sat32(fin);

  logic [33:0] diff;
  assign diff = 34'(signed'(t0_q)) - 34'(signed'(t1_q));

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      out_v_q <= 1'b0;
      n_q <= '0; i_q <= '0; j_q <= '0; ax_q <= '0; ph_q <= '0; which_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (out_v_q && rsp_o.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (req_i.valid && req_i.ready) begin
          rq_q <= req_i.data;
          if (req_i.data.func == FUNC_LOAD) begin
            if (load_we) total_q <= NW'(req_i.data.slot) + NW'(1);
          end else begin
            res_q.hit <= 1'b0;
            res_q.hit_time <= req_i.data.best_in;
            res_q.hit_plane <= '0;
            n_q <= total_q;
            e_q[0] <= sat32(XW'(req_i.data.vec_a_x) + XW'(req_i.data.vec_b_x));
            e_q[1] <= sat32(XW'(req_i.data.vec_a_y) + XW'(req_i.data.vec_b_y));
            e_q[2] <= sat32(XW'(req_i.data.vec_a_z) + XW'(req_i.data.vec_b_z));
            i_q <= '0;
            state_q <= S_END;
          end
        end
        S_END: begin
          if (i_q >= (AW+1)'(n_q)) state_q <= S_OUT;
          else begin
            which_q <= 1'b0; ax_q <= '0; acc_q <= '0; state_q <= S_PV;
          end
        end
        S_PV: state_q <= S_PV_ACC;
        S_PV_ACC: begin
          acc_q <= acc_q + pshift;
          if (ax_q == 2'd2) begin
            ax_q <= '0;
            state_q <= S_EVAL;
          end else ax_q <= ax_q + 2'd1;
        end
        S_EVAL: begin
          acc_q <= '0;
          if (!which_q) begin
            t0_q <= fv; which_q <= 1'b1; state_q <= S_PV_ACC;
          end else begin
            t1_q <= fv;
            which_q <= 1'b0;
            if (t0_q > 0 && fv > 0) state_q <= S_OUT;
            else if (t0_q >= 0 && fv <= 0 && t0_q > fv) begin
              rem_q <= '0;
              quo_q <= {t0_q[31:0], 16'd0};
              dcnt_q <= '0;
              state_q <= S_DIV;
            end else begin
              i_q <= i_q + 1'b1; state_q <= S_END;
            end
          end
        end
        S_DIV: begin
          begin : div_step
            logic [48:0] r2;
            logic [48:0] d2;
            r2 = {rem_q, quo_q[47]};
            d2 = 49'(diff);
            if (r2 >= d2) begin
              rem_q <= 48'(r2 - d2);
              quo_q <= {quo_q[46:0], 1'b1};
            end else begin
              rem_q <= r2[47:0];
              quo_q <= {quo_q[46:0], 1'b0};
            end
          end
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd47) state_q <= S_CPT;
          ax_q <= '0;
          ph_q <= '0;
        end
        S_CPT: begin
          if (ph_q == 2'd0) begin
            tm_q <= quo_q[TW-1:0];
            ph_q <= 2'd1;
            if (!(32'(rq_q.best_in) > 32'(quo_q[TW-1:0]))) begin
              i_q <= i_q + 1'b1; state_q <= S_END;
            end
          end else begin
            case (ax_q)
              2'd0: c_q[0] <= sat32(XW'(rq_q.vec_a_x) + pshift);
              2'd1: c_q[1] <= sat32(XW'(rq_q.vec_a_y) + pshift);
              default: c_q[2] <= sat32(XW'(rq_q.vec_a_z) + pshift);
            endcase
            if (ax_q == 2'd2) begin
              ax_q <= '0; j_q <= '0; state_q <= S_CHK_NEXT;
            end else ax_q <= ax_q + 2'd1;
          end
        end
        S_CHK_NEXT: begin
          if (j_q == i_q) j_q <= j_q + 1'b1;
          else if (j_q >= (AW+1)'(n_q)) begin
            res_q.hit <= 1'b1;
            res_q.hit_time <= tm_q;
            res_q.hit_plane <= SW'(i_q);
            state_q <= S_OUT;
          end else begin
            ax_q <= '0; acc_q <= '0; ph_q <= '0; state_q <= S_CHK_EVAL;
          end
        end
        S_CHK_EVAL: begin
          if (ph_q == 2'd0) ph_q <= 2'd1;
          else if (ph_q == 2'd1) begin
            acc_q <= acc_q + pshift;
            if (ax_q == 2'd2) ph_q <= 2'd2;
            else ax_q <= ax_q + 2'd1;
          end else begin
            if (fv > 0) begin
              i_q <= i_q + 1'b1; state_q <= S_END;
            end else begin
              j_q <= j_q + 1'b1; state_q <= S_CHK_NEXT;
            end
          end
        end
        S_OUT: begin
          if (!out_v_q || rsp_o.ready) begin
            out_q <= res_q;
            out_v_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !req_i.ready) else $error("ready while busy");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> out_v_q) else $error("result lost");
  a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.hit |-> out_q.hit_time <= 17'd65536) else $error("time range");
endmodule
